[src/srp_pkg.sv]
// Shared types and constants of the score rank percentile unit.
package srp_pkg;

    localparam int NUM_W = 24;
    localparam int DEN_W = 10;
    localparam int PCT_W = 14;
    localparam int ROLL_W = 7;
    localparam int TOTAL_W = 10;

    localparam logic [NUM_W-1:0] PCT_SCALE = 24'd10000;
    localparam logic [NUM_W-1:0] PCTL_SCALE = 24'd5000;
    localparam logic [PCT_W-1:0] PCT_SAT = 14'd10000;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

endpackage

[src/srp_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module srp_div
(
    input  logic              clk,
    input  logic              rst_n,
    input  srp_pkg::div_req_t req,
    output srp_pkg::div_rsp_t rsp
);

    localparam int NW = srp_pkg::NUM_W;
    localparam int DW = srp_pkg::DEN_W;
    localparam int SW = $clog2(NW + 1);

    logic [NW-1:0] quo_reg;
    logic [NW-1:0] quo_next;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] rem_next;
    logic [DW-1:0] den_reg;
    logic [SW-1:0] step_reg;
    logic [SW-1:0] step_next;
    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [DW:0]   shifted;
    logic          ge;

    assign shifted = {rem_reg, quo_reg[NW-1]};
    assign ge = shifted >= {1'b0, den_reg};

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            quo_next = req.num;
            rem_next = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NW-2:0], ge};
            rem_next = ge ? DW'(shifted - {1'b0, den_reg}) : shifted[DW-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(NW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quo = quo_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider reports done while still busy");

endmodule

[src/score_rank_percentile_unit.sv]
// Top level of the score rank percentile unit: record store, ranking and emission.
//
// Channel   Direction  Content
// s_axis    in         one record of four marks, tlast closes the set
// m_axis    out        one ranked record, tlast on the last record of the set
// cfg       in         max_mark write
//
// A record without tlast is accepted, stored while the record memory has room, and returns nothing.
// Ranking a set compares each record with every record of the set, one record compare per cycle
// through the single read port of the record memory.
// Each emitted record then waits on two 24-step divisions, one for the percentage and one for the percentile.
// Reset clears the record count and sets max_mark to 50; the memories need no clearing.
// A stalled output holds the pipeline; no input is taken while a set is being ranked.
module score_rank_percentile_unit
#(
    parameter int MAX_RECORDS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // mark_a, mark_b, mark_c, mark_d
    input  logic        s_tlast,   // final_record
    output logic        m_tvalid,
    input  logic        m_tready,
    // roll_number, out_mark_a, out_mark_b, out_mark_c, out_mark_d, total_marks,
    // percentage_hundredths, percentile_hundredths, zero fill
    output logic [79:0] m_tdata,
    output logic        m_tlast,   // end_of_run
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);

    localparam int IW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int OW = IW + 2 * CW;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_RANK_I = 9'b000000010,
        ST_RANK_T = 9'b000000100,
        ST_RANK_J = 9'b000001000,
        ST_E_ORD  = 9'b000010000,
        ST_E_REC  = 9'b000100000,
        ST_E_MUL  = 9'b001000000,
        ST_E_DIV  = 9'b010000000,
        ST_E_OUT  = 9'b100000000
    } state_t;

    logic [31:0] rec_mem [MAX_RECORDS];
    logic [OW-1:0] ord_mem [MAX_RECORDS];

    state_t state_reg;
    state_t state_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [CW-1:0] n_reg;
    logic [CW-1:0] n_next;
    logic [IW-1:0] i_reg;
    logic [IW-1:0] i_next;
    logic [IW-1:0] j_reg;
    logic [IW-1:0] j_next;
    logic [CW-1:0] lower_reg;
    logic [CW-1:0] lower_next;
    logic [CW-1:0] equal_reg;
    logic [CW-1:0] equal_next;
    logic [CW-1:0] pos_reg;
    logic [CW-1:0] pos_next;
    logic [srp_pkg::TOTAL_W-1:0] ti_reg;
    logic [srp_pkg::TOTAL_W-1:0] ti_next;
    logic second_reg;
    logic second_next;
    logic [7:0] max_mark_reg;

    logic [IW-1:0] rec_raddr;
    logic [31:0] rec_rdata;
    logic [OW-1:0] ord_rdata;
    logic rec_we;
    logic ord_we;
    logic [srp_pkg::TOTAL_W-1:0] rd_total;

    logic [IW-1:0] idx_reg;
    logic [31:0] marks_reg;
    logic [srp_pkg::TOTAL_W-1:0] total_reg;
    logic [srp_pkg::PCT_W-1:0] pct_reg;
    logic [srp_pkg::PCT_W-1:0] pctl_reg;
    logic [CW-1:0] elow_reg;
    logic [CW-1:0] eeq_reg;

    srp_pkg::div_req_t div_req;
    srp_pkg::div_rsp_t div_rsp;

    logic out_valid_reg;
    logic [79:0] out_data_reg;
    logic out_last_reg;
    logic out_free;
    logic last_pos;

    assign rd_total = srp_pkg::TOTAL_W'(rec_rdata[7:0]) + srp_pkg::TOTAL_W'(rec_rdata[15:8])
                    + srp_pkg::TOTAL_W'(rec_rdata[23:16]) + srp_pkg::TOTAL_W'(rec_rdata[31:24]);
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !out_valid_reg || m_tready;
    assign last_pos = (CW'(i_reg) == n_reg - 1'b1);
    assign rec_we = s_tvalid && s_tready && (count_reg < CW'(MAX_RECORDS));

    always_comb
    begin
        case (state_reg)
            ST_RANK_I: rec_raddr = i_reg;
            ST_RANK_T: rec_raddr = '0;
            ST_RANK_J: rec_raddr = IW'(j_reg + 1'b1);
            default:   rec_raddr = ord_rdata[OW-1 -: IW];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        n_next = n_reg;
        i_next = i_reg;
        j_next = j_reg;
        lower_next = lower_reg;
        equal_next = equal_reg;
        pos_next = pos_reg;
        ti_next = ti_reg;
        second_next = second_reg;
        ord_we = 1'b0;
        div_req.start = 1'b0;
        div_req.num = 24'(total_reg) * srp_pkg::PCT_SCALE;
        div_req.den = {max_mark_reg, 2'b00};
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (rec_we)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    if (s_tlast)
                    begin
                        n_next = count_next;
                        i_next = '0;
                        state_next = ST_RANK_I;
                    end
                end
            end
            ST_RANK_I:
            begin
                state_next = ST_RANK_T;
            end
            ST_RANK_T:
            begin
                ti_next = rd_total;
                j_next = '0;
                lower_next = '0;
                equal_next = '0;
                pos_next = '0;
                state_next = ST_RANK_J;
            end
            ST_RANK_J:
            begin
                if (rd_total < ti_reg)
                begin
                    lower_next = lower_reg + 1'b1;
                end
                if (rd_total == ti_reg)
                begin
                    equal_next = equal_reg + 1'b1;
                end
                if (rd_total > ti_reg || (rd_total == ti_reg && j_reg < i_reg))
                begin
                    pos_next = pos_reg + 1'b1;
                end
                j_next = IW'(j_reg + 1'b1);
                if (CW'(j_reg) == n_reg - 1'b1)
                begin
                    ord_we = 1'b1;
                    if (last_pos)
                    begin
                        i_next = '0;
                        state_next = ST_E_ORD;
                    end
                    else
                    begin
                        i_next = IW'(i_reg + 1'b1);
                        state_next = ST_RANK_I;
                    end
                end
            end
            ST_E_ORD:
            begin
                state_next = ST_E_REC;
            end
            ST_E_REC:
            begin
                state_next = ST_E_MUL;
            end
            ST_E_MUL:
            begin
                second_next = 1'b0;
                state_next = ST_E_DIV;
            end
            ST_E_DIV:
            begin
                if (!second_reg && !div_rsp.done)
                begin
                    div_req.start = (pct_reg == '1);
                end
                if (div_rsp.done)
                begin
                    if (!second_reg)
                    begin
                        second_next = 1'b1;
                        div_req.start = 1'b1;
                        div_req.num = 24'({elow_reg, 1'b0} + (CW + 1)'(eeq_reg))
                                    * srp_pkg::PCTL_SCALE;
                        div_req.den = srp_pkg::DEN_W'(n_reg);
                    end
                    else
                    begin
                        state_next = ST_E_OUT;
                    end
                end
            end
            ST_E_OUT:
            begin
                if (out_free)
                begin
                    if (last_pos)
                    begin
                        count_next = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        i_next = IW'(i_reg + 1'b1);
                        state_next = ST_E_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            n_reg <= '0;
            i_reg <= '0;
            j_reg <= '0;
            second_reg <= 1'b0;
            max_mark_reg <= 8'd50;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            n_reg <= n_next;
            i_reg <= i_next;
            j_reg <= j_next;
            second_reg <= second_next;
            if (cfg_wr_en)
            begin
                max_mark_reg <= cfg_wr_data;
            end
            if (state_reg == ST_E_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_we)
        begin
            rec_mem[count_reg[IW-1:0]] <= s_tdata;
        end
        rec_rdata <= rec_mem[rec_raddr];
        if (ord_we)
        begin
            ord_mem[pos_next[IW-1:0]] <= {i_reg, lower_next, equal_next};
        end
        ord_rdata <= ord_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        lower_reg <= lower_next;
        equal_reg <= equal_next;
        pos_reg <= pos_next;
        ti_reg <= ti_next;
        if (state_reg == ST_E_REC)
        begin
            idx_reg <= ord_rdata[OW-1 -: IW];
            elow_reg <= ord_rdata[2*CW-1 -: CW];
            eeq_reg <= ord_rdata[CW-1:0];
        end
        if (state_reg == ST_E_MUL)
        begin
            marks_reg <= rec_rdata;
            total_reg <= rd_total;
            pct_reg <= '1;
        end
        if (state_reg == ST_E_DIV && div_req.start && pct_reg == '1 && !div_rsp.done)
        begin
            pct_reg <= '0;
        end
        if (state_reg == ST_E_DIV && div_rsp.done)
        begin
            if (!second_reg)
            begin
                pct_reg <= (div_rsp.quo > 24'(srp_pkg::PCT_SAT))
                         ? srp_pkg::PCT_SAT : div_rsp.quo[srp_pkg::PCT_W-1:0];
            end
            else
            begin
                pctl_reg <= div_rsp.quo[srp_pkg::PCT_W-1:0];
            end
        end
        if (state_reg == ST_E_OUT && out_free)
        begin
            out_data_reg <= {3'b000, pctl_reg, pct_reg, total_reg, marks_reg,
                             srp_pkg::ROLL_W'(idx_reg) + 1'b1};
            out_last_reg <= last_pos;
        end
    end

    srp_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;
    assign m_tlast = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(MAX_RECORDS))
        else $error("record count beyond capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (n_reg != '0 && n_reg <= CW'(MAX_RECORDS)))
        else $error("ranking a set without records");

    assert property (@(posedge clk) disable iff (!rst_n) ord_we |-> (pos_next < n_reg))
        else $error("sorted position outside the set");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_E_OUT && out_free) |=> out_valid_reg)
        else $error("ranked record not presented");

endmodule

[tb/tb_top.sv]
// Testbench for the score rank percentile unit: random records, ranked-set prediction and checks.
`timescale 1ns / 100ps
module tb_top;

    localparam int CAP = 64;
    localparam int LIMIT = 3000000;

    typedef struct packed {
        logic [7:0] mark_a;
        logic [7:0] mark_b;
        logic [7:0] mark_c;
        logic [7:0] mark_d;
        logic       final_record;
    } record_t;

    typedef struct packed {
        logic [6:0]  roll_number;
        logic [7:0]  mark_a;
        logic [7:0]  mark_b;
        logic [7:0]  mark_c;
        logic [7:0]  mark_d;
        logic [9:0]  total_marks;
        logic [13:0] percentage;
        logic [13:0] percentile;
        logic        end_of_run;
    } ranked_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;
    logic        cfg_wr_en;
    logic [7:0]  cfg_wr_data;

    record_t pending_records[$];
    ranked_t expected_ranks[$];
    logic [31:0] held_records[CAP];
    int held_count;
    logic [7:0] model_max_mark;
    int errors;
    int cycles;
    int send_gap;
    int recv_gap;
    bit driving;

    score_rank_percentile_unit #(.MAX_RECORDS(CAP)) uut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always #5 clk = ~clk;

    function automatic int total_of(logic [31:0] r);
        return r[7:0] + r[15:8] + r[23:16] + r[31:24];
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 60);
    endfunction

    task automatic add_pending(record_t r);
        pending_records = {pending_records, r};
    endtask

    task automatic rank_set();
        int order[CAP];
        int n, i, j, t, lower, equal, pct;
        ranked_t e;
        n = held_count;
        for (i = 0; i < n; i++)
        begin
            t = total_of(held_records[i]);
            j = i;
            while (j > 0 && total_of(held_records[order[j-1]]) < t)
            begin
                order[j] = order[j-1];
                j--;
            end
            order[j] = i;
        end
        for (i = 0; i < n; i++)
        begin
            t = total_of(held_records[order[i]]);
            lower = 0;
            equal = 0;
            for (j = 0; j < n; j++)
            begin
                if (total_of(held_records[j]) < t)
                    lower++;
                else if (total_of(held_records[j]) == t)
                    equal++;
            end
            if (model_max_mark == 0)
                pct = 10000;
            else
            begin
                pct = (t * 10000) / (4 * model_max_mark);
                if (pct > 10000)
                    pct = 10000;
            end
            e.roll_number = 7'(order[i] + 1);
            e.mark_a = held_records[order[i]][7:0];
            e.mark_b = held_records[order[i]][15:8];
            e.mark_c = held_records[order[i]][23:16];
            e.mark_d = held_records[order[i]][31:24];
            e.total_marks = 10'(t);
            e.percentage = 14'(pct);
            e.percentile = 14'(((2 * lower + equal) * 5000) / n);
            e.end_of_run = (i == n - 1);
            expected_ranks = {expected_ranks, e};
        end
        held_count = 0;
    endtask

    task automatic predict(record_t r);
        if (held_count < CAP)
        begin
            held_records[held_count] = {r.mark_d, r.mark_c, r.mark_b, r.mark_a};
            held_count++;
        end
        if (r.final_record)
            rank_set();
    endtask

    always @(posedge clk)
    begin
        record_t r;
        if (s_tvalid && s_tready)
        begin
            predict(pending_records.pop_front());
            send_gap = pick_gap();
        end
        if (driving && pending_records.size() > 0 && send_gap == 0)
        begin
            r = pending_records[0];
            s_tvalid <= 1'b1;
            s_tdata <= {r.mark_d, r.mark_c, r.mark_b, r.mark_a};
            s_tlast <= r.final_record;
        end
        else
        begin
            s_tvalid <= 1'b0;
            if (send_gap > 0 && !(s_tvalid && !s_tready))
                send_gap--;
        end
    end

    always @(posedge clk)
    begin
        ranked_t e;
        if (m_tvalid && m_tready)
        begin
            if (expected_ranks.size() == 0)
            begin
                $error("unexpected result transaction: %h", m_tdata);
                errors++;
            end
            else
            begin
                e = expected_ranks.pop_front();
                if (m_tdata[6:0] !== e.roll_number)
                begin
                    $error("roll_number expected %0d actual %0d", e.roll_number, m_tdata[6:0]);
                    errors++;
                end
                if (m_tdata[14:7] !== e.mark_a)
                begin
                    $error("out_mark_a expected %0d actual %0d", e.mark_a, m_tdata[14:7]);
                    errors++;
                end
                if (m_tdata[22:15] !== e.mark_b)
                begin
                    $error("out_mark_b expected %0d actual %0d", e.mark_b, m_tdata[22:15]);
                    errors++;
                end
                if (m_tdata[30:23] !== e.mark_c)
                begin
                    $error("out_mark_c expected %0d actual %0d", e.mark_c, m_tdata[30:23]);
                    errors++;
                end
                if (m_tdata[38:31] !== e.mark_d)
                begin
                    $error("out_mark_d expected %0d actual %0d", e.mark_d, m_tdata[38:31]);
                    errors++;
                end
                if (m_tdata[48:39] !== e.total_marks)
                begin
                    $error("total_marks expected %0d actual %0d", e.total_marks,
                        m_tdata[48:39]);
                    errors++;
                end
                if (m_tdata[62:49] !== e.percentage)
                begin
                    $error("percentage_hundredths expected %0d actual %0d", e.percentage,
                        m_tdata[62:49]);
                    errors++;
                end
                if (m_tdata[76:63] !== e.percentile)
                begin
                    $error("percentile_hundredths expected %0d actual %0d", e.percentile,
                        m_tdata[76:63]);
                    errors++;
                end
                if (m_tlast !== e.end_of_run)
                begin
                    $error("end_of_run expected %0d actual %0d", e.end_of_run, m_tlast);
                    errors++;
                end
            end
        end
        if (recv_gap > 0)
        begin
            recv_gap--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                recv_gap = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("** score_rank_percentile_unit: FAILED **");
            $finish;
        end
    end

    function automatic record_t rand_record(bit last, int bias);
        record_t r;
        r.mark_a = (bias == 1) ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 255));
        r.mark_b = (bias == 2) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
        r.mark_c = 8'($urandom_range(0, 255));
        r.mark_d = ($urandom_range(0, 3) == 0) ? 8'd128 : 8'($urandom_range(0, 255));
        r.final_record = last;
        return r;
    endfunction

    task automatic queue_set(int n);
        int i;
        for (i = 0; i < n; i++)
            add_pending(rand_record(i == n - 1, $urandom_range(0, 3)));
    endtask

    task automatic drain_and_write(logic [7:0] value);
        wait (pending_records.size() == 0 && expected_ranks.size() == 0);
        driving = 1'b0;
        repeat (20) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        model_max_mark = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        driving = 1'b1;
    endtask

    initial
    begin
        int i, n, sent;
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        m_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        held_count = 0;
        model_max_mark = 8'd50;
        errors = 0;
        cycles = 0;
        send_gap = 0;
        recv_gap = 0;
        driving = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        driving = 1'b1;

        // Directed: extremes, single-record set, ties, default max_mark.
        add_pending('{8'd0, 8'd0, 8'd0, 8'd0, 1'b0});
        add_pending('{8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
        add_pending('{8'd10, 8'd20, 8'd30, 8'd40, 1'b0});
        add_pending('{8'd40, 8'd30, 8'd20, 8'd10, 1'b0});
        add_pending('{8'd50, 8'd50, 8'd50, 8'd50, 1'b1});
        add_pending('{8'd7, 8'd0, 8'd0, 8'd0, 1'b1});
        drain_and_write(8'd0);
        add_pending('{8'd1, 8'd2, 8'd3, 8'd4, 1'b0});
        add_pending('{8'd0, 8'd0, 8'd0, 8'd0, 1'b1});
        drain_and_write(8'd255);
        add_pending('{8'd255, 8'd255, 8'd255, 8'd255, 1'b0});
        add_pending('{8'd170, 8'd85, 8'd170, 8'd85, 1'b1});
        drain_and_write(8'd1);
        add_pending('{8'd0, 8'd1, 8'd0, 8'd0, 1'b0});
        add_pending('{8'd3, 8'd0, 8'd0, 8'd0, 1'b0});
        add_pending('{8'd85, 8'd170, 8'd85, 8'd170, 1'b1});

        // A full store with overflow, the final overflow record closing the set.
        drain_and_write(8'd50);
        for (i = 0; i < CAP + 3; i++)
            add_pending(rand_record(i == CAP + 2, 0));

        // Random sets, mostly small, with occasional register changes.
        sent = 0;
        while (sent < 36)
        begin
            if ($urandom_range(0, 4) == 0)
                drain_and_write(($urandom_range(0, 5) == 0) ? 8'd255
                                : 8'($urandom_range(1, 120)));
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
            queue_set(n);
            sent += n;
        end

        wait (pending_records.size() == 0 && expected_ranks.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("** score_rank_percentile_unit: PASSED **");
        else
            $display("** score_rank_percentile_unit: FAILED **");
        $finish;
    end

endmodule
